// ===== src/bpm_pkg.sv =====
// Shared types, register codes and reset values of the battery protection monitor.
package bpm_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VOLT_HIGH_SET   = 3'd0,
      CSR_VOLT_HIGH_CLEAR = 3'd1,
      CSR_VOLT_LOW_SET    = 3'd2,
      CSR_VOLT_LOW_CLEAR  = 3'd3,
      CSR_TEMP_LIMITS     = 3'd4,
      CSR_SOC_STEP        = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [15:0] VOLT_HIGH_SET_RST   = 16'd4350;
   localparam logic [15:0] VOLT_HIGH_CLEAR_RST = 16'd4250;
   localparam logic [15:0] VOLT_LOW_SET_RST    = 16'd3000;
   localparam logic [15:0] VOLT_LOW_CLEAR_RST  = 16'd3200;
   localparam logic [31:0] TEMP_LIMITS_RST     = 32'h0500_373C;
   localparam logic [6:0]  SOC_STEP_RST        = 7'd0;

   // Input sample
   typedef struct packed {
      logic [15:0] cell_voltage;
      logic [15:0] cell_temp;
      logic [7:0]  charge_percent;
   } req_type;

   // Result flags
   typedef struct packed {
      logic over_voltage;
      logic under_voltage;
      logic over_temp;
      logic under_temp;
      logic soc_event;
      logic alarm;
   } rsp_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [15:0] volt_high_set;
      logic [15:0] volt_high_clear;
      logic [15:0] volt_low_set;
      logic [15:0] volt_low_clear;
      logic [31:0] temp_limits_packed;
      logic [6:0]  soc_step;
   } cfg_type;

endpackage

// ===== src/bpm_csr.sv =====
// Configuration register file of the battery protection monitor.
module bpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bpm_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output bpm_pkg::cfg_type                     cfg
);

   bpm_pkg::cfg_type cfg_ff;
   bpm_pkg::cfg_type cfg_in;

   // Registers always take a write
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bpm_pkg::CSR_VOLT_HIGH_SET:   cfg_in.volt_high_set      = csr_data[15:0];
            bpm_pkg::CSR_VOLT_HIGH_CLEAR: cfg_in.volt_high_clear    = csr_data[15:0];
            bpm_pkg::CSR_VOLT_LOW_SET:    cfg_in.volt_low_set       = csr_data[15:0];
            bpm_pkg::CSR_VOLT_LOW_CLEAR:  cfg_in.volt_low_clear     = csr_data[15:0];
            bpm_pkg::CSR_TEMP_LIMITS:     cfg_in.temp_limits_packed = csr_data[31:0];
            bpm_pkg::CSR_SOC_STEP:        cfg_in.soc_step           = csr_data[6:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_high_set      <= bpm_pkg::VOLT_HIGH_SET_RST;
         cfg_ff.volt_high_clear    <= bpm_pkg::VOLT_HIGH_CLEAR_RST;
         cfg_ff.volt_low_set       <= bpm_pkg::VOLT_LOW_SET_RST;
         cfg_ff.volt_low_clear     <= bpm_pkg::VOLT_LOW_CLEAR_RST;
         cfg_ff.temp_limits_packed <= bpm_pkg::TEMP_LIMITS_RST;
         cfg_ff.soc_step           <= bpm_pkg::SOC_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bpm_core.sv =====
// Sample register, flag update logic and result register of the protection monitor.
module bpm_core (
   input  logic              clock,
   input  logic              reset,
   input  bpm_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpm_pkg::rsp_type  rsp_data
);

   localparam logic [15:0] TEMP_OFFSET = 16'd2731;
   localparam logic [7:0]  SOC_FULL    = 8'd100;

   typedef struct packed {
      logic over_voltage;
      logic under_voltage;
      logic over_temp;
      logic under_temp;
      logic full_hit;
      logic step_hit;
      logic empty_hit;
      logic latch;
      logic event_bit;
   } flag_state_type;

   // {hit, latch, event} after one SOC stage
   typedef struct packed {
      logic hit;
      logic latch;
      logic event_bit;
   } soc_stage_type;

   // Signed degree-C byte to 0.1 K: c*10 + 2731, always positive
   function automatic logic [15:0] temp_limit(input logic [7:0] deg);
      logic signed [15:0] c;
      logic signed [15:0] k;
      c = {{8{deg[7]}}, deg};
      k = (c <<< 3) + (c <<< 1) + $signed(TEMP_OFFSET);
      return k;
   endfunction

   function automatic soc_stage_type soc_stage(input logic hit, input logic latch,
                                               input logic event_bit, input logic cond);
      soc_stage_type s;
      s = '{hit: hit, latch: latch, event_bit: event_bit};
      if (hit && latch) begin
         s.event_bit = 1'b0;
         if (!cond) begin
            s.hit   = 1'b0;
            s.latch = 1'b0;
         end
      end else if (!hit && cond) begin
         s.event_bit = 1'b1;
         s.hit       = 1'b1;
         s.latch     = 1'b1;
      end
      return s;
   endfunction

   logic              in_valid_ff;
   bpm_pkg::req_type  in_data_ff;
   logic              rsp_valid_ff;
   bpm_pkg::rsp_type  rsp_data_ff;
   bpm_pkg::rsp_type  rsp_data_in;
   flag_state_type    state_ff;
   flag_state_type    state_in;
   logic              advance;

   logic [15:0]   th_high_set;
   logic [15:0]   th_high_clear;
   logic [15:0]   th_low_set;
   logic [15:0]   th_low_clear;
   logic [7:0]    step_level;
   logic          step_ok;
   soc_stage_type st_full;
   soc_stage_type st_step;
   soc_stage_type st_empty;

   // Handshake: the sample moves on whenever the result slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Temperature limits in 0.1 K
   assign th_high_set   = temp_limit(cfg.temp_limits_packed[7:0]);
   assign th_high_clear = temp_limit(cfg.temp_limits_packed[15:8]);
   assign th_low_set    = temp_limit(cfg.temp_limits_packed[23:16]);
   assign th_low_clear  = temp_limit(cfg.temp_limits_packed[31:24]);

   // Delta level; a step above 100 never matches
   assign step_ok    = ({1'b0, cfg.soc_step} <= SOC_FULL);
   assign step_level = SOC_FULL - {1'b0, cfg.soc_step};

   // Flag update for the held sample: set check then clear check
   always_comb begin
      state_in = state_ff;

      if (!state_in.over_voltage && in_data_ff.cell_voltage > cfg.volt_high_set)
         state_in.over_voltage = 1'b1;
      if (state_in.over_voltage && in_data_ff.cell_voltage < cfg.volt_high_clear)
         state_in.over_voltage = 1'b0;

      if (!state_in.under_voltage && in_data_ff.cell_voltage < cfg.volt_low_set)
         state_in.under_voltage = 1'b1;
      if (state_in.under_voltage && in_data_ff.cell_voltage > cfg.volt_low_clear)
         state_in.under_voltage = 1'b0;

      if (!state_in.over_temp && in_data_ff.cell_temp > th_high_set)
         state_in.over_temp = 1'b1;
      if (state_in.over_temp && in_data_ff.cell_temp < th_high_clear)
         state_in.over_temp = 1'b0;

      if (!state_in.under_temp && in_data_ff.cell_temp < th_low_set)
         state_in.under_temp = 1'b1;
      if (state_in.under_temp && in_data_ff.cell_temp > th_low_clear)
         state_in.under_temp = 1'b0;

      // SOC chain: full, delta, empty share the latch and event bit
      st_full  = soc_stage(state_ff.full_hit, state_ff.latch, state_ff.event_bit,
                           in_data_ff.charge_percent >= SOC_FULL);
      st_step  = soc_stage(state_ff.step_hit, st_full.latch, st_full.event_bit,
                           step_ok && (in_data_ff.charge_percent == step_level));
      st_empty = soc_stage(state_ff.empty_hit, st_step.latch, st_step.event_bit,
                           in_data_ff.charge_percent == 8'd0);

      if (cfg.soc_step != 7'd0) begin
         state_in.full_hit  = st_full.hit;
         state_in.step_hit  = st_step.hit;
         state_in.empty_hit = st_empty.hit;
         state_in.latch     = st_empty.latch;
         state_in.event_bit = st_empty.event_bit;
      end else begin
         state_in.full_hit  = 1'b0;
         state_in.step_hit  = 1'b0;
         state_in.empty_hit = 1'b0;
         state_in.latch     = 1'b0;
         state_in.event_bit = 1'b0;
      end

      rsp_data_in.over_voltage  = state_in.over_voltage;
      rsp_data_in.under_voltage = state_in.under_voltage;
      rsp_data_in.over_temp     = state_in.over_temp;
      rsp_data_in.under_temp    = state_in.under_temp;
      rsp_data_in.soc_event     = state_in.event_bit;
      rsp_data_in.alarm         = state_in.over_voltage | state_in.under_voltage |
                                  state_in.over_temp | state_in.under_temp |
                                  state_in.event_bit;
   end

   // Control and flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready)
            in_valid_ff <= req_valid;
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_data_ff <= req_data;
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/battery_protection_monitor.sv =====
// Top level of the battery protection monitor.
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_data  (cell_voltage, cell_temp, charge_percent)
//  rsp_      out        rsp_valid / rsp_ready  rsp_data  (four flags, soc_event, alarm)
//  csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// One sample per cycle while results are taken; a result is registered after its sample's transfer,
// passing the sample register, then the result register, and a stalled result holds both.
// The flag update is a single pass of compares between those two registers.
// Reset (synchronous) clears all flags, the SOC latch/event state and loads default limits.
// While a result waits on rsp_ready, one more sample is still taken into the sample register.
// csr_ready is always high; a write is registered in the configuration registers.
module battery_protection_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bpm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bpm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bpm_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   bpm_pkg::cfg_type cfg;

   bpm_csr u_bpm_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpm_core u_bpm_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/bpm_checker.sv =====
// Port-level checker of the battery protection monitor and its bind.
module bpm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input bpm_pkg::rsp_type                     rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Alarm is the OR of the flags and the SOC event
   a_alarm_or: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.alarm == (rsp_data.over_voltage || rsp_data.under_voltage ||
                                       rsp_data.over_temp || rsp_data.under_temp ||
                                       rsp_data.soc_event))
      else $error("alarm does not match flags");

   // A new result needs an earlier sample transfer through the sample register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a sample");

   // Reset empties the result slot
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind battery_protection_monitor bpm_checker u_bpm_checker (.*);

// ===== bench/battery_protection_monitor_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the battery protection monitor: directed and random samples.

module battery_protection_monitor_test;

   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 100;
   localparam longint WATCHDOG_NS = 5_000_000;
   localparam int TEMP_OFFSET_DK = 2731;
   localparam int TEMP_SCALE_DK = 10;
   localparam int CHARGE_FULL = 100;
   // indexes past the register map, writes there must be ignored
   localparam logic [bpm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [bpm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   // Flag predictor and queue of expected results
   class protection_scoreboard;
      logic [15:0] volt_high_set;
      logic [15:0] volt_high_clear;
      logic [15:0] volt_low_set;
      logic [15:0] volt_low_clear;
      logic [31:0] temp_limits;
      logic [6:0]  soc_step;
      bit over_volt, under_volt, over_hot, under_cold;
      bit full_hit, empty_hit, step_hit, soc_latch, soc_event;
      bpm_pkg::rsp_type expected_flags[$];
      int errors;

      function new();
         volt_high_set   = bpm_pkg::VOLT_HIGH_SET_RST;
         volt_high_clear = bpm_pkg::VOLT_HIGH_CLEAR_RST;
         volt_low_set    = bpm_pkg::VOLT_LOW_SET_RST;
         volt_low_clear  = bpm_pkg::VOLT_LOW_CLEAR_RST;
         temp_limits     = bpm_pkg::TEMP_LIMITS_RST;
         soc_step        = bpm_pkg::SOC_STEP_RST;
         errors          = 0;
      endfunction

      function void write_reg(logic [bpm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              logic [bpm_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            bpm_pkg::CSR_VOLT_HIGH_SET:   volt_high_set = data[15:0];
            bpm_pkg::CSR_VOLT_HIGH_CLEAR: volt_high_clear = data[15:0];
            bpm_pkg::CSR_VOLT_LOW_SET:    volt_low_set = data[15:0];
            bpm_pkg::CSR_VOLT_LOW_CLEAR:  volt_low_clear = data[15:0];
            bpm_pkg::CSR_TEMP_LIMITS:     temp_limits = data;
            bpm_pkg::CSR_SOC_STEP:        soc_step = data[6:0];
            default: ;
         endcase
      endfunction

      // signed degree-C byte converted to 0.1 K
      function int temp_limit_dk(int unsigned slot);
         logic signed [7:0] deg;
         deg = temp_limits[8*slot +: 8];
         return int'(deg) * TEMP_SCALE_DK + TEMP_OFFSET_DK;
      endfunction

      // one SOC check sharing the latch and event bit
      function void soc_stage(inout bit hit, input bit cond);
         if (hit && soc_latch) begin
            soc_event = 1'b0;
            if (!cond) begin
               hit = 1'b0;
               soc_latch = 1'b0;
            end
         end else if (!hit && cond) begin
            soc_event = 1'b1;
            hit = 1'b1;
            soc_latch = 1'b1;
         end
      endfunction

      function void note_sample(bpm_pkg::req_type s);
         int temp_dk;
         int charge;
         bpm_pkg::rsp_type r;
         temp_dk = int'(s.cell_temp);
         charge = int'(s.charge_percent);

         // set check first, then clear check, on the same sample
         if (!over_volt && s.cell_voltage > volt_high_set) over_volt = 1'b1;
         if (over_volt && s.cell_voltage < volt_high_clear) over_volt = 1'b0;
         if (!under_volt && s.cell_voltage < volt_low_set) under_volt = 1'b1;
         if (under_volt && s.cell_voltage > volt_low_clear) under_volt = 1'b0;
         if (!over_hot && temp_dk > temp_limit_dk(0)) over_hot = 1'b1;
         if (over_hot && temp_dk < temp_limit_dk(1)) over_hot = 1'b0;
         if (!under_cold && temp_dk < temp_limit_dk(2)) under_cold = 1'b1;
         if (under_cold && temp_dk > temp_limit_dk(3)) under_cold = 1'b0;

         // SOC checks: full, delta, empty; zero step clears all SOC state
         if (soc_step != 0) begin
            soc_stage(full_hit, charge >= CHARGE_FULL);
            soc_stage(step_hit, charge == CHARGE_FULL - int'(soc_step));
            soc_stage(empty_hit, charge == 0);
         end else begin
            soc_event = 1'b0;
            soc_latch = 1'b0;
            full_hit = 1'b0;
            empty_hit = 1'b0;
            step_hit = 1'b0;
         end

         r.over_voltage  = over_volt;
         r.under_voltage = under_volt;
         r.over_temp     = over_hot;
         r.under_temp    = under_cold;
         r.soc_event     = soc_event;
         r.alarm         = over_volt | under_volt | over_hot | under_cold | soc_event;
         expected_flags.push_back(r);
      endfunction

      function void compare_bit(string field, logic want, logic got);
         if (got !== want) begin
            errors++;
            $display("%0d ns: mismatch on %s, expected %b, actual %b",
                     $time, field, want, got);
         end
      endfunction

      function void check_result(bpm_pkg::rsp_type got);
         bpm_pkg::rsp_type want;
         if (expected_flags.size() == 0) begin
            errors++;
            $display("%0d ns: unexpected result, expected none, actual %b", $time, got);
            return;
         end
         want = expected_flags.pop_front();
         compare_bit("over_voltage", want.over_voltage, got.over_voltage);
         compare_bit("under_voltage", want.under_voltage, got.under_voltage);
         compare_bit("over_temp", want.over_temp, got.over_temp);
         compare_bit("under_temp", want.under_temp, got.under_temp);
         compare_bit("soc_event", want.soc_event, got.soc_event);
         compare_bit("alarm", want.alarm, got.alarm);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   bpm_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   bpm_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [bpm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bpm_pkg::CSR_DATA_WIDTH-1:0]  csr_data;

   bit steady;    // no idling on either side while set
   protection_scoreboard board;

   battery_protection_monitor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #HALF_PERIOD_NS clock = 1'b1;
      #HALF_PERIOD_NS clock = 1'b0;
   end

   // Monitor: results are checked before the same edge's sample is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (req_valid && req_ready) board.note_sample(req_data);
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
      end
   end

   // Gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: bursts of ready with random stalls between them
   initial begin
      int unsigned open_len;
      int unsigned stall_len;
      rsp_ready = 1'b0;
      forever begin
         open_len = $urandom_range(1, 6);
         stall_len = pick_gap();
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (open_len - 1) @(negedge clock);
         if (stall_len > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clock);
         end
      end
   end

   // One sample transfer, after a random gap with junk on the bus
   task automatic send_sample(input bpm_pkg::req_type s);
      int unsigned gap;
      logic [63:0] noise;
      gap = pick_gap();
      repeat (gap) begin
         noise = {$urandom, $urandom};
         @(negedge clock);
         req_valid <= 1'b0;
         req_data <= noise[39:0];
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drive_sample(input logic [15:0] v, input logic [15:0] t,
                               input logic [7:0] c);
      bpm_pkg::req_type s;
      s.cell_voltage = v;
      s.cell_temp = t;
      s.charge_percent = c;
      send_sample(s);
   endtask

   task automatic write_csr(input logic [bpm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [bpm_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every expected result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_flags.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // All six registers plus one spare index, unused upper data bits filled with noise
   task automatic apply_settings(input logic [15:0] hs, input logic [15:0] hc,
                                 input logic [15:0] ls, input logic [15:0] lc,
                                 input logic [31:0] temps, input logic [6:0] step);
      write_csr(bpm_pkg::CSR_VOLT_HIGH_SET, {16'($urandom), hs});
      write_csr(bpm_pkg::CSR_VOLT_HIGH_CLEAR, {16'($urandom), hc});
      write_csr(bpm_pkg::CSR_VOLT_LOW_SET, {16'($urandom), ls});
      write_csr(bpm_pkg::CSR_VOLT_LOW_CLEAR, {16'($urandom), lc});
      write_csr(bpm_pkg::CSR_TEMP_LIMITS, temps);
      write_csr(bpm_pkg::CSR_SOC_STEP, {25'($urandom), step});
      write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
   endtask

   function automatic logic [15:0] pick_extreme16();
      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
   endfunction

   task automatic randomize_settings();
      logic [15:0] hs, hc, ls, lc;
      logic [7:0]  t_hs, t_hc, t_ls, t_lc;
      logic [31:0] temps;
      logic [6:0]  step;
      int unsigned r;

      // voltage window: realistic, extreme or anything at all
      case ($urandom_range(0, 3))
         0, 1: begin
            hs = 16'($urandom_range(4000, 4500));
            hc = hs - 16'($urandom_range(0, 200));
            ls = 16'($urandom_range(2500, 3200));
            lc = ls + 16'($urandom_range(0, 200));
         end
         2: begin
            hs = pick_extreme16();
            hc = pick_extreme16();
            ls = pick_extreme16();
            lc = pick_extreme16();
         end
         default: begin
            hs = 16'($urandom);
            hc = 16'($urandom);
            ls = 16'($urandom);
            lc = 16'($urandom);
         end
      endcase

      // temperature bytes in degrees C
      case ($urandom_range(0, 3))
         0, 1: begin
            t_hs = 8'($urandom_range(30, 90));
            t_hc = t_hs - 8'($urandom_range(0, 10));
            t_ls = 8'($urandom_range(0, 50)) - 8'd40;
            t_lc = t_ls + 8'($urandom_range(0, 10));
            temps = {t_lc, t_ls, t_hc, t_hs};
         end
         2: temps = {$urandom_range(0, 1) ? 8'h7F : 8'h80, $urandom_range(0, 1) ? 8'h7F : 8'h80,
                     $urandom_range(0, 1) ? 8'h7F : 8'h80, $urandom_range(0, 1) ? 8'h7F : 8'h80};
         default: temps = $urandom;
      endcase

      // SOC step: off, edges, past 100 or ordinary
      r = $urandom_range(0, 9);
      case (r)
         0, 1: step = 7'd0;
         2: step = 7'd1;
         3: step = 7'd100;
         4: step = 7'($urandom_range(101, 127));
         default: step = 7'($urandom_range(2, 99));
      endcase

      apply_settings(hs, hc, ls, lc, temps, step);
   endtask

   // Random sample, aimed near the current limits most of the time
   function automatic bpm_pkg::req_type random_sample();
      bpm_pkg::req_type s;
      logic [15:0] edges [4];
      int t_edge;

      edges[0] = board.volt_high_set;
      edges[1] = board.volt_high_clear;
      edges[2] = board.volt_low_set;
      edges[3] = board.volt_low_clear;
      if ($urandom_range(0, 9) < 6)
         s.cell_voltage = edges[$urandom_range(0, 3)] + 16'($urandom_range(0, 6)) - 16'd3;
      else
         s.cell_voltage = 16'($urandom);

      if ($urandom_range(0, 9) < 6) begin
         t_edge = board.temp_limit_dk($urandom_range(0, 3)) + int'($urandom_range(0, 6)) - 3;
         s.cell_temp = 16'(t_edge);
      end else begin
         s.cell_temp = 16'($urandom);
      end

      case ($urandom_range(0, 9))
         0, 1: s.charge_percent = ($urandom_range(0, 3) == 0) ?
                                  8'($urandom_range(101, 255)) : 8'(CHARGE_FULL);
         2, 3: s.charge_percent = (int'(board.soc_step) <= CHARGE_FULL) ?
                                  8'(CHARGE_FULL - int'(board.soc_step)) : 8'($urandom);
         4, 5: s.charge_percent = 8'd0;
         6: s.charge_percent = 8'($urandom_range(98, 102));
         7: s.charge_percent = 8'($urandom_range(0, 2));
         default: s.charge_percent = 8'($urandom);
      endcase
      return s;
   endfunction

   // Main sequence
   initial begin
      board = new();
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default limits, SOC off: field extremes and exact threshold values
      drive_sample(16'd0, 16'd0, 8'd0);
      drive_sample(16'hFFFF, 16'hFFFF, 8'hFF);
      drive_sample(16'd4300, 16'd3300, 8'd50);
      drive_sample(16'd4249, 16'd3280, 8'd100);
      drive_sample(16'd3000, 16'd2731, 8'd0);
      drive_sample(16'd2999, 16'd2730, 8'd0);
      drive_sample(16'd3200, 16'd2781, 8'd0);
      drive_sample(16'd3201, 16'd2782, 8'd0);

      // SOC step of 10: full, delta and empty crossings through the shared latch
      wait_drained();
      apply_settings(bpm_pkg::VOLT_HIGH_SET_RST, bpm_pkg::VOLT_HIGH_CLEAR_RST,
                     bpm_pkg::VOLT_LOW_SET_RST, bpm_pkg::VOLT_LOW_CLEAR_RST,
                     bpm_pkg::TEMP_LIMITS_RST, 7'd10);
      drive_sample(16'd3500, 16'd2981, 8'd100);
      drive_sample(16'd3500, 16'd2981, 8'd100);
      drive_sample(16'd3500, 16'd2981, 8'd90);
      drive_sample(16'd3500, 16'd2981, 8'd90);
      drive_sample(16'd3500, 16'd2981, 8'd0);
      drive_sample(16'd3500, 16'd2981, 8'd255);
      drive_sample(16'd3500, 16'd2981, 8'd50);

      // inverted limits: set and clear on one sample; step past 100 never matches
      wait_drained();
      apply_settings(16'd100, 16'd200, 16'd500, 16'd400, 32'h807F_7F80, 7'd127);
      drive_sample(16'd150, 16'd3000, 8'd27);
      drive_sample(16'd450, 16'd1000, 8'd100);

      // all limits at the top, step of 100 puts delta on the empty point
      wait_drained();
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7F7F_7F7F, 7'd100);
      drive_sample(16'hFFFF, 16'hFFFF, 8'd0);
      drive_sample(16'd0, 16'd0, 8'd0);
      drive_sample(16'd0, 16'd0, 8'd1);

      // all limits at zero, smallest step
      wait_drained();
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000, 7'd1);
      drive_sample(16'd0, 16'd0, 8'd99);
      drive_sample(16'd1, 16'hFFFF, 8'd100);

      // random phases, each with fresh settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         steady = ($urandom_range(0, 3) == 0);
         randomize_settings();
         for (int n = 0; n < PHASE_SAMPLES; n++)
            send_sample(random_sample());
      end

      wait_drained();
      if (board.errors == 0 && board.expected_flags.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #(WATCHDOG_NS);
      $display("timeout at %0d ns", $time);
      $display("status: fail");
      $finish;
   end

endmodule
